// ----- rtl/card_word_machine_executor_macros.svh -----
// Assertion macros for the card word machine executor.
// Depends on nothing; included by the top level.
`ifndef CARD_WORD_MACHINE_EXECUTOR_MACROS_SVH
`define CARD_WORD_MACHINE_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CWME_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CWME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cwme_pkg.sv -----
// Shared types, constants and helpers for the card word machine executor.
// Depends on nothing.
package cwme_pkg;

  localparam int MEM_WORDS   = 100;
  localparam int CARD_WORDS  = 10;
  localparam int PRINT_WORDS = 10;
  localparam int MA_W        = $clog2(MEM_WORDS);

  localparam logic [31:0] BLANK_WORD = 32'h20202020;
  localparam logic [7:0]  CH_G = 8'h47;
  localparam logic [7:0]  CH_P = 8'h50;
  localparam logic [7:0]  CH_H = 8'h48;
  localparam logic [7:0]  CH_L = 8'h4C;
  localparam logic [7:0]  CH_S = 8'h53;
  localparam logic [7:0]  CH_C = 8'h43;
  localparam logic [7:0]  CH_B = 8'h42;
  localparam logic [7:0]  CH_T = 8'h54;
  localparam logic [7:0]  CH_D = 8'h44;
  localparam logic [7:0]  CH_R = 8'h52;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_STEP   = 3'd2;
  localparam logic [2:0] OP_CARD   = 3'd3;
  localparam logic [2:0] OP_NOCARD = 3'd4;

  typedef enum logic [2:0] {
    KIND_DONE  = 3'd0,
    KIND_PRINT = 3'd1,
    KIND_HALT  = 3'd2,
    KIND_WAIT  = 3'd3,
    KIND_ERR   = 3'd4,
    KIND_EMPTY = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_HALT = 2'd2,
    MODE_ERR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DECODE,
    ST_OPER,
    ST_PRINT,
    ST_PRINT_LAST
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_DISPATCH,
    CMD_DECODE,
    CMD_OPER,
    CMD_PRINT,
    CMD_PRINT_LAST
  } cmd_t;

  // What the datapath reports back to the controller.
  typedef struct packed {
    logic fetch;       // dispatch issued an instruction fetch
    logic dec_oper;    // decode issued an operand read for LR or CR
    logic dec_print;   // decode started a print run
    logic print_more;  // print issued the next read
    logic print_full;  // print run reached its word limit
  } sts_t;

  function automatic kind_t status_kind(input mode_t m);
    kind_t k;
    unique case (m)
      MODE_WAIT: k = KIND_WAIT;
      MODE_HALT: k = KIND_HALT;
      MODE_ERR:  k = KIND_ERR;
      default:   k = KIND_DONE;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/cwme_ctrl.sv -----
// Sequencer for the card word machine executor.
// Depends on cwme_pkg; drives commands into cwme_datapath.
module cwme_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  cwme_pkg::sts_t  sts,
  output cwme_pkg::cmd_t  cmd,
  output logic            busy
);

  cwme_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cwme_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cwme_pkg::ST_IDLE: begin
        if (start) state_nxt = cwme_pkg::ST_DISPATCH;
      end
      cwme_pkg::ST_DISPATCH: begin
        state_nxt = sts.fetch ? cwme_pkg::ST_DECODE : cwme_pkg::ST_IDLE;
      end
      cwme_pkg::ST_DECODE: begin
        if (sts.dec_oper) state_nxt = cwme_pkg::ST_OPER;
        else if (sts.dec_print) state_nxt = cwme_pkg::ST_PRINT;
        else state_nxt = cwme_pkg::ST_IDLE;
      end
      cwme_pkg::ST_PRINT: begin
        if (sts.print_more) state_nxt = cwme_pkg::ST_PRINT;
        else if (sts.print_full) state_nxt = cwme_pkg::ST_PRINT_LAST;
        else state_nxt = cwme_pkg::ST_IDLE;
      end
      cwme_pkg::ST_OPER,
      cwme_pkg::ST_PRINT_LAST: state_nxt = cwme_pkg::ST_IDLE;
      default: state_nxt = cwme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    unique case (state_r)
      cwme_pkg::ST_IDLE: begin
        cmd  = cwme_pkg::CMD_NONE;
        busy = 1'b0;
      end
      cwme_pkg::ST_DISPATCH:   cmd = cwme_pkg::CMD_DISPATCH;
      cwme_pkg::ST_DECODE:     cmd = cwme_pkg::CMD_DECODE;
      cwme_pkg::ST_OPER:       cmd = cwme_pkg::CMD_OPER;
      cwme_pkg::ST_PRINT:      cmd = cwme_pkg::CMD_PRINT;
      cwme_pkg::ST_PRINT_LAST: cmd = cwme_pkg::CMD_PRINT_LAST;
      default:                 cmd = cwme_pkg::CMD_NONE;
    endcase
  end

endmodule

// ----- rtl/cwme_datapath.sv -----
// Word store, machine registers and result register of the executor.
// Depends on cwme_pkg; commanded by cwme_ctrl.
module cwme_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [2:0]      in_opcode,
  input  logic [6:0]      in_load_address,
  input  logic [31:0]     in_data_word,
  input  logic            in_card_last,
  input  cwme_pkg::cmd_t  cmd,
  output cwme_pkg::sts_t  sts,
  output logic            out_strobe,
  output logic [2:0]      out_kind,
  output logic [31:0]     out_print_word,
  output logic            out_run_last,
  output logic [6:0]      out_counter_now,
  output logic            out_toggle_now
);

  localparam logic [6:0] MEM_LIM  = 7'(cwme_pkg::MEM_WORDS);
  localparam logic [4:0] CARD_LIM = 5'(cwme_pkg::CARD_WORDS);
  localparam logic [3:0] PRN_LIM  = 4'(cwme_pkg::PRINT_WORDS);

  // Latched input word.
  logic [2:0]  op_r;
  logic [6:0]  la_r;
  logic [31:0] dw_r;
  logic        cl_r;

  // Machine state.
  logic [31:0]         greg_r, greg_nxt;
  logic [6:0]          ic_r, ic_nxt;
  logic                flag_r, flag_nxt;
  cwme_pkg::mode_t     mode_r, mode_nxt;
  logic [6:0]          cptr_r, cptr_nxt;
  logic [3:0]          ccnt_r, ccnt_nxt;
  logic [6:0]          loc_r, loc_nxt;
  logic                isld_r, isld_nxt;
  logic [3:0]          pcnt_r, pcnt_nxt;
  logic [31:0]         pend_r, pend_nxt;

  // Word store with per-entry valid bits; an invalid entry reads as blank.
  logic [31:0]                    mem [cwme_pkg::MEM_WORDS];
  logic [cwme_pkg::MEM_WORDS-1:0] vld_r;
  logic [31:0]                    rd_data_r;
  logic                           rd_vld_r, rd_in_r;
  logic                           we, re, clr;
  logic [6:0]                     wa, ra;
  logic [31:0]                    wd, rd_word;

  // Result register inputs.
  logic                ov;
  cwme_pkg::kind_t     okind;
  logic [31:0]         oword;
  logic                olast;

  // Decode of the word just read.
  logic [7:0] c0, c1, c2, c3;
  logic       uses_addr, d2_ok, d3_ok, op_ok;
  logic [6:0] oper_addr;
  logic [6:0] pnext;
  logic [3:0] pinc;
  logic [3:0] ccnt_inc;
  logic       cur_ok;

  assign rd_word = rd_vld_r ? rd_data_r : cwme_pkg::BLANK_WORD;
  assign c0 = rd_word[31:24];
  assign c1 = rd_word[23:16];
  assign c2 = rd_word[15:8];
  assign c3 = rd_word[7:0];
  assign uses_addr = (c0 == cwme_pkg::CH_G && c1 == cwme_pkg::CH_D) ||
                     (c0 == cwme_pkg::CH_P && c1 == cwme_pkg::CH_D) ||
                     (c0 == cwme_pkg::CH_L && c1 == cwme_pkg::CH_R) ||
                     (c0 == cwme_pkg::CH_S && c1 == cwme_pkg::CH_R) ||
                     (c0 == cwme_pkg::CH_C && c1 == cwme_pkg::CH_R) ||
                     (c0 == cwme_pkg::CH_B && c1 == cwme_pkg::CH_T);
  assign d2_ok = (c2 >= cwme_pkg::CH_ZERO) && (c2 <= cwme_pkg::CH_NINE);
  assign d3_ok = (c3 >= cwme_pkg::CH_ZERO) && (c3 <= cwme_pkg::CH_NINE);

  always_comb begin
    if (c2 == cwme_pkg::CH_SPACE || c3 == cwme_pkg::CH_SPACE) begin
      oper_addr = 7'd0;
      op_ok     = 1'b1;
    end else begin
      oper_addr = 7'(c2[3:0]) * 7'd10 + 7'(c3[3:0]);
      op_ok     = d2_ok && d3_ok && (oper_addr < MEM_LIM);
    end
  end

  assign pinc     = pcnt_r + 4'd1;
  assign pnext    = loc_r + 7'(pinc);
  assign ccnt_inc = ccnt_r + 4'd1;
  assign cur_ok   = rd_in_r && (rd_word != cwme_pkg::BLANK_WORD);

  always_comb begin
    greg_nxt = greg_r;
    ic_nxt   = ic_r;
    flag_nxt = flag_r;
    mode_nxt = mode_r;
    cptr_nxt = cptr_r;
    ccnt_nxt = ccnt_r;
    loc_nxt  = loc_r;
    isld_nxt = isld_r;
    pcnt_nxt = pcnt_r;
    pend_nxt = pend_r;
    we = 1'b0; wa = 7'd0; wd = dw_r;
    re = 1'b0; ra = 7'd0; clr = 1'b0;
    ov = 1'b0; okind = cwme_pkg::KIND_DONE; oword = 32'd0; olast = 1'b1;
    sts = '0;
    case (cmd)
      cwme_pkg::CMD_DISPATCH: begin
        ov = 1'b1;
        okind = cwme_pkg::status_kind(mode_r);
        unique case (op_r)
          cwme_pkg::OP_CLEAR: begin
            clr = 1'b1;
            ic_nxt = 7'd0; flag_nxt = 1'b0; mode_nxt = cwme_pkg::MODE_RUN;
            cptr_nxt = 7'd0; ccnt_nxt = 4'd0;
            okind = cwme_pkg::KIND_DONE;
          end
          cwme_pkg::OP_LOAD: begin
            if (la_r < MEM_LIM) begin
              we = 1'b1; wa = la_r;
              okind = cwme_pkg::KIND_DONE;
            end else begin
              okind = cwme_pkg::KIND_ERR;
            end
          end
          cwme_pkg::OP_STEP: begin
            if (mode_r == cwme_pkg::MODE_RUN) begin
              if (ic_r >= MEM_LIM) begin
                mode_nxt = cwme_pkg::MODE_ERR;
                okind = cwme_pkg::KIND_ERR;
              end else begin
                ov = 1'b0; re = 1'b1; ra = ic_r; sts.fetch = 1'b1;
              end
            end
          end
          cwme_pkg::OP_CARD: begin
            if (mode_r == cwme_pkg::MODE_WAIT) begin
              if (cptr_r >= MEM_LIM) begin
                mode_nxt = cwme_pkg::MODE_ERR;
                okind = cwme_pkg::KIND_ERR;
              end else begin
                we = 1'b1; wa = cptr_r;
                cptr_nxt = cptr_r + 7'd1;
                ccnt_nxt = ccnt_inc;
                if (cl_r || ({1'b0, ccnt_inc} >= CARD_LIM)) begin
                  mode_nxt = cwme_pkg::MODE_RUN;
                  okind = cwme_pkg::KIND_DONE;
                end else begin
                  okind = cwme_pkg::KIND_WAIT;
                end
              end
            end
          end
          cwme_pkg::OP_NOCARD: begin
            if (mode_r == cwme_pkg::MODE_WAIT) begin
              mode_nxt = cwme_pkg::MODE_RUN;
              okind = cwme_pkg::KIND_DONE;
            end
          end
          default: ;
        endcase
      end
      cwme_pkg::CMD_DECODE: begin
        ic_nxt = ic_r + 7'd1;
        ov = 1'b1;
        okind = cwme_pkg::KIND_DONE;
        if (c0 == cwme_pkg::CH_H) begin
          mode_nxt = cwme_pkg::MODE_HALT;
          okind = cwme_pkg::KIND_HALT;
        end else if (uses_addr) begin
          if (!op_ok) begin
            mode_nxt = cwme_pkg::MODE_ERR;
            okind = cwme_pkg::KIND_ERR;
          end else if (c0 == cwme_pkg::CH_G) begin
            cptr_nxt = oper_addr; ccnt_nxt = 4'd0;
            mode_nxt = cwme_pkg::MODE_WAIT;
            okind = cwme_pkg::KIND_WAIT;
          end else if (c0 == cwme_pkg::CH_P) begin
            ov = 1'b0; re = 1'b1; ra = oper_addr;
            loc_nxt = oper_addr; pcnt_nxt = 4'd0;
            sts.dec_print = 1'b1;
          end else if (c0 == cwme_pkg::CH_L || c0 == cwme_pkg::CH_C) begin
            ov = 1'b0; re = 1'b1; ra = oper_addr;
            isld_nxt = (c0 == cwme_pkg::CH_L);
            sts.dec_oper = 1'b1;
          end else if (c0 == cwme_pkg::CH_S) begin
            we = 1'b1; wa = oper_addr; wd = greg_r;
          end else if (flag_r) begin
            ic_nxt = oper_addr;
          end
        end
      end
      cwme_pkg::CMD_OPER: begin
        ov = 1'b1;
        okind = cwme_pkg::KIND_DONE;
        if (isld_r) greg_nxt = rd_word;
        else flag_nxt = (greg_r == rd_word);
      end
      cwme_pkg::CMD_PRINT: begin
        if (cur_ok) begin
          // The previous word goes out now; the last one waits for lookahead.
          if (pcnt_r != 4'd0) begin
            ov = 1'b1; okind = cwme_pkg::KIND_PRINT; oword = pend_r; olast = 1'b0;
          end
          pend_nxt = rd_word;
          pcnt_nxt = pinc;
          if (pinc == PRN_LIM) begin
            sts.print_full = 1'b1;
          end else begin
            re = 1'b1; ra = pnext;
            sts.print_more = 1'b1;
          end
        end else if (pcnt_r == 4'd0) begin
          ov = 1'b1; okind = cwme_pkg::KIND_EMPTY;
        end else begin
          ov = 1'b1; okind = cwme_pkg::KIND_PRINT; oword = pend_r;
        end
      end
      cwme_pkg::CMD_PRINT_LAST: begin
        ov = 1'b1; okind = cwme_pkg::KIND_PRINT; oword = pend_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_opcode;
      la_r <= in_load_address;
      dw_r <= in_data_word;
      cl_r <= in_card_last;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa[cwme_pkg::MA_W-1:0]] <= wd;
    if (re && ra < MEM_LIM) rd_data_r <= mem[ra[cwme_pkg::MA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      rd_in_r  <= 1'b0;
    end else begin
      if (clr) vld_r <= '0;
      else if (we) vld_r[wa[cwme_pkg::MA_W-1:0]] <= 1'b1;
      if (re) begin
        rd_in_r  <= (ra < MEM_LIM);
        rd_vld_r <= (ra < MEM_LIM) && vld_r[ra[cwme_pkg::MA_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      greg_r     <= cwme_pkg::BLANK_WORD;
      ic_r       <= 7'd0;
      flag_r     <= 1'b0;
      mode_r     <= cwme_pkg::MODE_RUN;
      cptr_r     <= 7'd0;
      ccnt_r     <= 4'd0;
      out_strobe <= 1'b0;
    end else begin
      greg_r     <= greg_nxt;
      ic_r       <= ic_nxt;
      flag_r     <= flag_nxt;
      mode_r     <= mode_nxt;
      cptr_r     <= cptr_nxt;
      ccnt_r     <= ccnt_nxt;
      out_strobe <= ov;
    end
  end

  always_ff @(posedge clk) begin
    loc_r  <= loc_nxt;
    isld_r <= isld_nxt;
    pcnt_r <= pcnt_nxt;
    pend_r <= pend_nxt;
    if (ov) begin
      out_kind        <= okind;
      out_print_word  <= oword;
      out_run_last    <= olast;
      out_counter_now <= ic_nxt;
      out_toggle_now  <= flag_nxt;
    end
  end

endmodule

// ----- rtl/card_word_machine_executor.sv -----
// Card word machine executor: a 100-word stored-program machine stepped by command words.
// A result is registered at dispatch; for a step at decode, for LR/CR at the operand read.
// A new word is taken only once the last has finished; a PD prints up to 10 words.
// Every cycle is bounded by the word store read, whose data is registered.
// Reset is synchronous, active low, and blanks the store at once through per-word valid bits.
// Results cannot be stalled; each strobes for exactly one cycle.
`include "card_word_machine_executor_macros.svh"

module card_word_machine_executor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [6:0]  in_load_address,
  input  logic [31:0] in_data_word,
  input  logic        in_card_last,
  output logic        out_strobe,
  output logic [2:0]  out_kind,
  output logic [31:0] out_print_word,
  output logic        out_run_last,
  output logic [6:0]  out_counter_now,
  output logic        out_toggle_now
);

  // The controller walks dispatch, decode, operand access and the print
  // loop; the datapath holds the word store and all machine registers.
  cwme_pkg::cmd_t cmd;
  cwme_pkg::sts_t sts;
  logic           accept;

  // A word is taken only while the sequencer sits idle.
  assign accept = start && !busy;

  cwme_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  cwme_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_opcode       (in_opcode),
    .in_load_address (in_load_address),
    .in_data_word    (in_data_word),
    .in_card_last    (in_card_last),
    .cmd             (cmd),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_print_word  (out_print_word),
    .out_run_last    (out_run_last),
    .out_counter_now (out_counter_now),
    .out_toggle_now  (out_toggle_now)
  );

  // An accepted word must occupy the sequencer on the following cycle.
  `CWME_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not start work")
  // A print run delivers its words on consecutive cycles.
  `CWME_ASSERT_NEXT(a_print_run, out_strobe && !out_run_last, out_strobe, "print run broke")
  // Only printed words may be followed by more results.
  `CWME_ASSERT_NOW(a_single_last, out_strobe && out_kind != 3'(cwme_pkg::KIND_PRINT),
                   out_run_last, "non-print result not marked last")

endmodule

// ----- tb/cwme_checker.sv -----
// Scoreboard for the card word machine executor: predicts every result word and compares.
// Depends on cwme_pkg; instantiated beside the block by tb_card_word_machine_executor.
module cwme_checker import cwme_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [6:0]  in_load_address,
  input  logic [31:0] in_data_word,
  input  logic        in_card_last,
  input  logic        out_strobe,
  input  logic [2:0]  out_kind,
  input  logic [31:0] out_print_word,
  input  logic        out_run_last,
  input  logic [6:0]  out_counter_now,
  input  logic        out_toggle_now,
  output int          errors,
  output int          outstanding
);

  typedef struct {
    kind_t       kind;
    logic [31:0] word;
    logic        last;
    logic [6:0]  counter;
    logic        flag;
  } reply_t;

  reply_t      replies[$];
  logic [31:0] mem_words[MEM_WORDS];
  logic [31:0] acc_word;
  logic [6:0]  pc;
  logic        flag;
  mode_t       mode;
  logic [6:0]  card_ptr;
  logic [3:0]  card_cnt;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic push_reply(input kind_t k, input logic [31:0] w, input logic last);
    reply_t r;
    r.kind = k; r.word = w; r.last = last; r.counter = pc; r.flag = flag;
    replies.push_back(r);
  endtask

  function automatic kind_t mode_kind();
    case (mode)
      MODE_WAIT: return KIND_WAIT;
      MODE_HALT: return KIND_HALT;
      MODE_ERR:  return KIND_ERR;
      default:   return KIND_DONE;
    endcase
  endfunction

  task automatic wipe_machine();
    for (int i = 0; i < MEM_WORDS; i++) mem_words[i] = BLANK_WORD;
    pc = '0; flag = 1'b0; mode = MODE_RUN; card_ptr = '0; card_cnt = '0;
  endtask

  // One instruction: fetch, decode, then act on the operand.
  task automatic run_instruction();
    logic [31:0] ir;
    logic [7:0]  c0, c1, c2, c3;
    logic        addressed, ok;
    int          loc, n;
    if (mode != MODE_RUN) begin
      push_reply(mode_kind(), '0, 1'b1);
      return;
    end
    if (pc >= MEM_WORDS) begin
      mode = MODE_ERR;
      push_reply(KIND_ERR, '0, 1'b1);
      return;
    end
    ir = mem_words[pc];
    pc = pc + 7'd1;
    {c0, c1, c2, c3} = ir;
    if (c0 == CH_H) begin
      mode = MODE_HALT;
      push_reply(KIND_HALT, '0, 1'b1);
      return;
    end
    addressed = (c0 == CH_G && c1 == CH_D) || (c0 == CH_P && c1 == CH_D) ||
                (c0 == CH_L && c1 == CH_R) || (c0 == CH_S && c1 == CH_R) ||
                (c0 == CH_C && c1 == CH_R) || (c0 == CH_B && c1 == CH_T);
    if (!addressed) begin
      push_reply(KIND_DONE, '0, 1'b1);
      return;
    end
    // A blank in either digit position means address zero.
    ok = 1'b1;
    loc = 0;
    if (c2 != CH_SPACE && c3 != CH_SPACE) begin
      if (c2 < CH_ZERO || c2 > CH_NINE || c3 < CH_ZERO || c3 > CH_NINE) ok = 1'b0;
      else loc = (c2 - CH_ZERO) * 10 + (c3 - CH_ZERO);
      if (loc >= MEM_WORDS) ok = 1'b0;
    end
    if (!ok) begin
      mode = MODE_ERR;
      push_reply(KIND_ERR, '0, 1'b1);
      return;
    end
    if (c0 == CH_G) begin
      card_ptr = loc[6:0]; card_cnt = '0; mode = MODE_WAIT;
      push_reply(KIND_WAIT, '0, 1'b1);
    end else if (c0 == CH_P) begin
      n = 0;
      while (n < PRINT_WORDS && loc + n < MEM_WORDS && mem_words[loc + n] != BLANK_WORD) n++;
      if (n == 0) push_reply(KIND_EMPTY, '0, 1'b1);
      for (int k = 0; k < n; k++) push_reply(KIND_PRINT, mem_words[loc + k], k == n - 1);
    end else begin
      if (c0 == CH_L) acc_word = mem_words[loc];
      else if (c0 == CH_S) mem_words[loc] = acc_word;
      else if (c0 == CH_C) flag = (acc_word == mem_words[loc]);
      else if (flag) pc = loc[6:0];
      push_reply(KIND_DONE, '0, 1'b1);
    end
  endtask

  task automatic take_word(input logic [2:0] op, input logic [6:0] addr,
                           input logic [31:0] data, input logic last);
    kind_t k;
    if (op == OP_STEP) begin
      run_instruction();
      return;
    end
    if (op == OP_CLEAR) begin
      wipe_machine();
      k = KIND_DONE;
    end else if (op == OP_LOAD) begin
      if (addr < MEM_WORDS) begin
        mem_words[addr] = data;
        k = KIND_DONE;
      end else k = KIND_ERR;
    end else if (op == OP_CARD && mode == MODE_WAIT) begin
      if (card_ptr >= MEM_WORDS) begin
        mode = MODE_ERR;
        k = KIND_ERR;
      end else begin
        mem_words[card_ptr] = data;
        card_ptr = card_ptr + 7'd1;
        card_cnt = card_cnt + 4'd1;
        if (last || card_cnt >= CARD_WORDS) begin
          mode = MODE_RUN;
          k = KIND_DONE;
        end else k = KIND_WAIT;
      end
    end else if (op == OP_NOCARD && mode == MODE_WAIT) begin
      mode = MODE_RUN;
      k = KIND_DONE;
    end else k = mode_kind();
    push_reply(k, '0, 1'b1);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    reply_t e;
    if (!rst_n) begin
      wipe_machine();
      acc_word = BLANK_WORD;
      replies.delete();
    end else begin
      // Results come only after their word has been dispatched, so order here is free.
      if (out_strobe) begin
        if (replies.size() == 0) report("result word with nothing expected");
        else begin
          e = replies.pop_front();
          if (out_kind !== e.kind)
            report($sformatf("kind %0d, expected %0d", out_kind, e.kind));
          if (out_print_word !== e.word)
            report($sformatf("print word %h, expected %h", out_print_word, e.word));
          if (out_run_last !== e.last)
            report($sformatf("last flag %b, expected %b", out_run_last, e.last));
          if (out_counter_now !== e.counter)
            report($sformatf("counter %0d, expected %0d", out_counter_now, e.counter));
          if (out_toggle_now !== e.flag)
            report($sformatf("flag %b, expected %b", out_toggle_now, e.flag));
        end
      end
      if (start && !busy) take_word(in_opcode, in_load_address, in_data_word, in_card_last);
    end
    outstanding <= replies.size();
  end

endmodule

// ----- tb/tb_card_word_machine_executor.sv -----
// Top of the testbench for the card word machine executor: clock, reset, stimulus, verdict.
// Depends on cwme_pkg, the block itself and the cwme_checker scoreboard.
module tb_card_word_machine_executor;
  import cwme_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_opcode;
  logic [6:0]  in_load_address;
  logic [31:0] in_data_word;
  logic        in_card_last;
  logic        out_strobe;
  logic [2:0]  out_kind;
  logic [31:0] out_print_word;
  logic        out_run_last;
  logic [6:0]  out_counter_now;
  logic        out_toggle_now;
  int          errors;
  int          outstanding;
  bit          gaps_on;

  card_word_machine_executor dut (.*);

  cwme_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: even the slowest legal run is far shorter than this.
  initial begin
    #3000000;
    $display("tb_card_word_machine_executor NOT OK");
    $finish;
  end

  // Offers one word and returns at the edge that accepts it. The start line is
  // left high so that a following word goes out back to back.
  task automatic issue_word(input logic [2:0] op, input logic [6:0] addr,
                            input logic [31:0] data, input logic last);
    while (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_load_address <= addr;
    in_data_word    <= data;
    in_card_last    <= last;
    do @(posedge clk); while (busy);
  endtask

  // Builds an instruction word from two letters and a two-digit operand.
  function automatic logic [31:0] instr(input logic [7:0] a, input logic [7:0] b,
                                        input int operand);
    return {a, b, CH_ZERO + 8'(operand / 10), CH_ZERO + 8'(operand % 10)};
  endfunction

  // A random instruction: mostly known opcodes whose operands land in the
  // small region used by programs, with some blank, bad and far operands.
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    int          pick;
    pick = $urandom_range(7);
    case (pick)
      0: w = instr(CH_G, CH_D, $urandom_range(19));
      1: w = instr(CH_P, CH_D, $urandom_range(19));
      2: w = instr(CH_L, CH_R, $urandom_range(19));
      3: w = instr(CH_S, CH_R, $urandom_range(19));
      4: w = instr(CH_C, CH_R, $urandom_range(19));
      5: w = instr(CH_B, CH_T, $urandom_range(9));
      6: w = {CH_H, 8'($urandom), 16'($urandom)};
      default: w = $urandom;
    endcase
    case ($urandom_range(9))
      0: w[7:0] = CH_SPACE;
      1: w[15:8] = 8'($urandom);
      2: w[15:0] = {CH_NINE, CH_NINE};
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [2:0]  op;
    logic [6:0]  addr;
    logic [31:0] data;
    int          roll;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_CLEAR;
    in_load_address = '0;
    in_data_word = '0;
    in_card_last = 1'b0;
    gaps_on = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed program: a card read, a print, register moves, a compare and a
    // taken branch onto an unknown opcode, then a bad operand.
    issue_word(OP_CLEAR, '0, '0, 1'b0);
    issue_word(OP_LOAD, 7'd0, instr(CH_G, CH_D, 20), 1'b0);
    issue_word(OP_LOAD, 7'd1, instr(CH_P, CH_D, 20), 1'b0);
    issue_word(OP_LOAD, 7'd2, instr(CH_L, CH_R, 20), 1'b0);
    issue_word(OP_LOAD, 7'd3, instr(CH_S, CH_R, 30), 1'b0);
    issue_word(OP_LOAD, 7'd4, instr(CH_C, CH_R, 30), 1'b0);
    issue_word(OP_LOAD, 7'd5, instr(CH_B, CH_T, 7), 1'b0);
    issue_word(OP_LOAD, 7'd7, 32'h58583132, 1'b0);
    issue_word(OP_LOAD, 7'd8, {CH_P, CH_D, CH_NINE, 8'h5A}, 1'b0);
    issue_word(OP_LOAD, 7'd99, 32'hFFFFFFFF, 1'b0);
    issue_word(OP_LOAD, 7'd127, 32'h00000000, 1'b0);
    issue_word(OP_STEP, '0, '0, 1'b0);
    issue_word(OP_CARD, '0, 32'h41424344, 1'b0);
    issue_word(OP_CARD, '0, 32'h45464748, 1'b1);
    for (int i = 0; i < 7; i++) issue_word(OP_STEP, '0, '0, 1'b0);
    issue_word(OP_CARD, '0, 32'h12345678, 1'b1);
    issue_word(OP_NOCARD, '0, '0, 1'b0);
    issue_word(3'd7, '0, '0, 1'b0);

    // Random programs. Each begins with a clear and a few loads, then mixes
    // steps, card traffic and noise. A stretch in the middle runs without gaps.
    for (int n = 0; n < 90; n++) begin
      gaps_on = !(n >= 35 && n < 65);
      roll = $urandom_range(99);
      addr = 7'($urandom_range(19));
      data = $urandom;
      if (n % 30 == 0) begin
        issue_word(OP_CLEAR, '0, data, 1'($urandom));
        for (int i = 0; i < 8; i++) issue_word(OP_LOAD, 7'(i), random_instr(), 1'b0);
        continue;
      end
      if (roll < 45) op = OP_STEP;
      else if (roll < 65) op = OP_CARD;
      else if (roll < 72) op = OP_NOCARD;
      else if (roll < 87) op = OP_LOAD;
      else if (roll < 90) op = OP_CLEAR;
      else op = 3'($urandom_range(7));
      if (op == OP_LOAD) begin
        if ($urandom_range(5) == 0) addr = 7'($urandom);
        if ($urandom_range(1)) data = random_instr();
      end
      if ($urandom_range(7) == 0) data = BLANK_WORD;
      issue_word(op, addr, data, $urandom_range(3) == 0);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_card_word_machine_executor OK");
    end else begin
      $display("tb_card_word_machine_executor NOT OK");
    end
    $finish;
  end

endmodule
